FILE: sv/als_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants of the acceleration-limited step-rate block.
// No dependencies; every other file imports this package.
package als_pkg;

   localparam int AXIS_W       = 3;
   localparam int POS_W        = 32;
   localparam int VEL_W        = 32;
   localparam int LIMIT_W      = 31;
   localparam int STEPS_W      = 31;
   localparam int HALF_W       = 31;
   localparam int PERIOD_W     = 25;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 25'd1000;

   localparam int NUM_AXES_DEF  = 8;
   localparam int CLOCK_MHZ_DEF = 133;

   // Step timing constants: pulses for at most MIN_STEPS steps are not generated,
   // the half-period loses HALF_OFFSET ticks and is set to 1 if it would fall below MIN_TICKS.
   localparam int MIN_STEPS   = 2;
   localparam int HALF_OFFSET = 15;
   localparam int MIN_TICKS   = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DELTA,
      ST_CLAMP,
      ST_MAG,
      ST_DIV_START,
      ST_DIV,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic delta;
      logic clamp;
      logic mag;
      logic div_start;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic out_busy;
   } dp_status_type;

endpackage

FILE: sv/als_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying one axis update.
// Depends on als_pkg for the field widths.
interface als_req_if
   import als_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [AXIS_W-1:0]    axis_index;
   logic [POS_W-1:0]     target_position;
   logic [POS_W-1:0]     current_position;
   logic [LIMIT_W-1:0]   accel_limit;
   logic [STEPS_W-1:0]   steps_reported;

   modport source (
      output valid, axis_index, target_position, current_position, accel_limit,
             steps_reported,
      input  ready
   );

   modport sink (
      input  valid, axis_index, target_position, current_position, accel_limit,
             steps_reported,
      output ready
   );
endinterface

FILE: sv/als_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: valid/ready handshake carrying one step-rate result.
// Depends on als_pkg for the field widths.
interface als_rsp_if
   import als_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [HALF_W-1:0]        half_period_ticks;
   logic                     direction;
   logic signed [VEL_W-1:0]  limited_velocity;
   logic [POS_W-1:0]         new_position;
   logic signed [VEL_W-1:0]  achieved_velocity;

   modport source (
      output valid, half_period_ticks, direction, limited_velocity, new_position,
             achieved_velocity,
      input  ready
   );

   modport sink (
      input  valid, half_period_ticks, direction, limited_velocity, new_position,
             achieved_velocity,
      output ready
   );
endinterface

FILE: sv/als_divider.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on als_pkg only for the velocity width of the divisor.
module als_divider
   import als_pkg::*;
#(
   parameter int DIVIDEND_W = 33
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [VEL_W-1:0]      divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [VEL_W:0]        rem_ff,  rem_in;
   logic [DIVIDEND_W-1:0] quo_ff,  quo_in;
   logic [VEL_W-1:0]      div_ff,  div_in;
   logic [CNT_W-1:0]      cnt_ff,  cnt_in;
   logic                  busy_ff, busy_in;
   logic [VEL_W+1:0]      trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      // The partial remainder stays below the divisor, so its top bit is free.
      trial   = {1'b0, rem_ff[VEL_W-1:0], quo_ff[DIVIDEND_W-1]} - {2'b00, div_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[VEL_W+1]) begin
            rem_in = trial[VEL_W:0];
         end else begin
            rem_in = {rem_ff[VEL_W-1:0], quo_ff[DIVIDEND_W-1]};
         end
         quo_in = {quo_ff[DIVIDEND_W-2:0], ~trial[VEL_W+1]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: sv/als_datapath.sv
`timescale 1ns / 1ps
// Datapath: input capture, velocity store, clamp, step timing and output register.
// Depends on als_pkg and instantiates als_divider.
module als_datapath
   import als_pkg::*;
#(
   parameter int NUM_AXES  = NUM_AXES_DEF,
   parameter int CLOCK_MHZ = CLOCK_MHZ_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             cmd,
   output dp_status_type            status,
   input  logic                     csr_wr_en,
   input  logic [PERIOD_W-1:0]      csr_wr_data,
   input  logic [AXIS_W-1:0]        in_axis,
   input  logic [POS_W-1:0]         in_target,
   input  logic [POS_W-1:0]         in_current,
   input  logic [LIMIT_W-1:0]       in_limit,
   input  logic [STEPS_W-1:0]       in_steps,
   input  logic                     out_ready,
   output logic                     out_valid,
   output logic [HALF_W-1:0]        out_half,
   output logic                     out_dir,
   output logic signed [VEL_W-1:0]  out_applied,
   output logic [POS_W-1:0]         out_newpos,
   output logic signed [VEL_W-1:0]  out_achieved
);

   localparam int MHZ_W  = $clog2(CLOCK_MHZ + 1);
   localparam int PROD_W = PERIOD_W + MHZ_W;
   localparam int Q_W    = (PROD_W > 32) ? PROD_W : 32;

   logic [PERIOD_W-1:0]     period_ff;
   logic [AXIS_W-1:0]       axis_ff;
   logic [POS_W-1:0]        target_ff, current_ff;
   logic [LIMIT_W-1:0]      limit_ff;
   logic [STEPS_W-1:0]      steps_ff;
   logic signed [VEL_W-1:0] vel_ff [NUM_AXES];
   logic signed [VEL_W-1:0] last_ff, req_ff, applied_ff;
   logic signed [VEL_W:0]   delta_ff;
   logic [VEL_W-1:0]        mag_ff;
   logic                    dir_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [POS_W-1:0]        newpos_ff;
   logic [VEL_W-1:0]        achieved_ff;
   logic                    out_valid_ff;

   logic                    axis_valid;
   logic signed [VEL_W-1:0] last_in, req_in, applied_in;
   logic signed [VEL_W:0]   delta_in, sum_w;
   logic signed [VEL_W+1:0] delta_x, limit_x;
   logic                    div_busy;
   logic [PROD_W-1:0]       quotient;
   logic [Q_W-1:0]          q, q_less;
   logic [HALF_W-1:0]       half_in;

   assign axis_valid = ({{(32-AXIS_W){1'b0}}, axis_ff} < 32'(NUM_AXES));

   always_comb begin
      last_in = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         if (axis_valid && axis_ff == AXIS_W'(i)) begin
            last_in = vel_ff[i];
         end
      end
      req_in   = signed'(target_ff - current_ff);
      delta_in = {req_in[VEL_W-1], req_in} - {last_in[VEL_W-1], last_in};
   end

   // The clamped value lies between the stored and the requested velocity.
   always_comb begin
      delta_x = {delta_ff[VEL_W], delta_ff};
      limit_x = signed'({3'b000, limit_ff});
      sum_w   = {req_ff[VEL_W-1], req_ff};
      if (delta_x > limit_x) begin
         sum_w = {last_ff[VEL_W-1], last_ff} + signed'({2'b00, limit_ff});
      end else if (delta_x < -limit_x) begin
         sum_w = {last_ff[VEL_W-1], last_ff} - signed'({2'b00, limit_ff});
      end
      applied_in = sum_w[VEL_W-1:0];
      if ((applied_in > 0 && last_ff < 0) || (applied_in < 0 && last_ff > 0)) begin
         applied_in = '0;
      end
   end

   always_comb begin
      q      = Q_W'(quotient >> 1);
      q_less = q - Q_W'(HALF_OFFSET);
      if (mag_ff <= 32'(MIN_STEPS)) begin
         half_in = '0;
      end else if (q < Q_W'(HALF_OFFSET + MIN_TICKS)) begin
         half_in = HALF_W'(1);
      end else if (q_less > Q_W'({HALF_W{1'b1}})) begin
         half_in = {HALF_W{1'b1}};
      end else begin
         half_in = q_less[HALF_W-1:0];
      end
   end

   als_divider #(
      .DIVIDEND_W (PROD_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (mag_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         axis_ff    <= in_axis;
         target_ff  <= in_target;
         current_ff <= in_current;
         limit_ff   <= in_limit;
         steps_ff   <= in_steps;
      end
      if (cmd.delta) begin
         last_ff  <= last_in;
         req_ff   <= req_in;
         delta_ff <= delta_in;
      end
      if (cmd.clamp) begin
         applied_ff <= applied_in;
      end
      if (cmd.mag) begin
         dir_ff  <= (applied_ff > 0);
         mag_ff  <= applied_ff[VEL_W-1] ? (~applied_ff + 1'b1) : applied_ff;
         prod_ff <= PROD_W'(period_ff) * PROD_W'(CLOCK_MHZ);
         if (applied_ff > 0) begin
            newpos_ff   <= current_ff + {1'b0, steps_ff};
            achieved_ff <= {1'b0, steps_ff};
         end else begin
            newpos_ff   <= current_ff - {1'b0, steps_ff};
            achieved_ff <= ~{1'b0, steps_ff} + 1'b1;
         end
      end
      if (cmd.out_load) begin
         out_half     <= half_in;
         out_dir      <= dir_ff;
         out_applied  <= applied_ff;
         out_newpos   <= newpos_ff;
         out_achieved <= signed'(achieved_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_RESET;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) begin
            vel_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
         if (cmd.clamp && axis_valid) begin
            for (int i = 0; i < NUM_AXES; i++) begin
               if (axis_ff == AXIS_W'(i)) begin
                  vel_ff[i] <= applied_in;
               end
            end
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign out_valid       = out_valid_ff;
   assign status.div_busy = div_busy;
   assign status.out_busy = out_valid_ff && !out_ready;

endmodule

FILE: sv/als_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing one update through the datapath.
// Depends on als_pkg for the state, command and status types.
module als_ctrl
   import als_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // Nothing is taken while reset is held.
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_DELTA;
            end
         end
         ST_DELTA: begin
            cmd.delta = 1'b1;
            state_in  = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_MAG;
         end
         ST_MAG: begin
            cmd.mag  = 1'b1;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Wait until the output register is free or is being emptied.
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/accel_limited_step_rate.sv
`timescale 1ns / 1ps
// Acceleration-limited step-rate generator. A request goes through capture, velocity
// difference, clamp, magnitude, divider start, the divider over a dividend of
// PW = 25 + clog2(CLOCK_MHZ + 1) bits (33 at the default), and the response register.
// Synchronous active-high reset clears all stored axis velocities to zero,
// sets period_us to 1000 and empties the response register.
// Depends on als_pkg, als_req_if, als_rsp_if, als_divider, als_datapath and als_ctrl.
module accel_limited_step_rate
   import als_pkg::*;
#(
   parameter int NUM_AXES  = NUM_AXES_DEF,
   parameter int CLOCK_MHZ = CLOCK_MHZ_DEF
) (
   input  logic                clock,
   input  logic                reset,
   als_req_if.sink             req_chan,
   als_rsp_if.source           rsp_chan,
   input  logic                csr_wr_en,
   input  logic [PERIOD_W-1:0] csr_wr_data
);

   // The controller walks each request transaction through capture, velocity
   // difference, clamp, magnitude and product, then runs the divider for the step
   // half-period. The result goes into an output register, so a new request
   // transaction can be accepted while the previous response still waits.
   // Each axis keeps its last applied velocity; an axis number of NUM_AXES or
   // above reads zero and leaves the store untouched.

   ctrl_cmd_type  cmd;
   dp_status_type status;

   als_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   als_datapath #(
      .NUM_AXES  (NUM_AXES),
      .CLOCK_MHZ (CLOCK_MHZ)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .in_axis      (req_chan.axis_index),
      .in_target    (req_chan.target_position),
      .in_current   (req_chan.current_position),
      .in_limit     (req_chan.accel_limit),
      .in_steps     (req_chan.steps_reported),
      .out_ready    (rsp_chan.ready),
      .out_valid    (rsp_chan.valid),
      .out_half     (rsp_chan.half_period_ticks),
      .out_dir      (rsp_chan.direction),
      .out_applied  (rsp_chan.limited_velocity),
      .out_newpos   (rsp_chan.new_position),
      .out_achieved (rsp_chan.achieved_velocity)
   );

endmodule
